// ----- rtl/vfr_pkg.sv -----
package vfr_pkg;

    localparam int PHASE_BITS = 32;

    localparam int FREQ_W   = 26;
    localparam int ACC_W    = 31;
    localparam int IDX_W    = 17;
    localparam int PWM_W    = 20;
    localparam int PH_OUT_W = 32;
    localparam int CFG_W    = 31;
    localparam int CFG_IDX_W = 3;

    localparam int Q30_SH  = 30;
    localparam int RAMP_SH = Q30_SH - FREQ_W;
    localparam int PROD_W  = FREQ_W + ACC_W;
    localparam int IDX_PROD_W = IDX_W + FREQ_W;

    // divider: remainder as wide as the widest divisor, quotient wide enough for the phase step
    localparam int REM_W  = ACC_W;
    localparam int DIV_QW = FREQ_W + PHASE_BITS - 16;
    localparam int CNT_W  = $clog2(DIV_QW + 1);

    localparam int IN_DATA_W  = 32;
    localparam int OUT_USED_W = FREQ_W + IDX_W + PH_OUT_W;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

    localparam logic [ACC_W-1:0]  ONE_Q30   = ACC_W'(1) << Q30_SH;
    localparam logic [IDX_W-1:0]  IDX_MAX   = '1;
    localparam logic [ACC_W-1:0]  ACCEL_RST = 31'd1074815566;
    localparam logic [IDX_W-1:0]  NOM_IDX_RST = 17'd52429;
    localparam logic [FREQ_W-1:0] NOM_FREQ_RST = 26'd3276800;
    localparam logic [PWM_W-1:0]  PWM_RST = 20'd20000;
    localparam logic [FREQ_W-1:0] INIT_FREQ_RST = 26'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACCEL     = 3'd0,
        CFG_NOM_IDX   = 3'd1,
        CFG_NOM_FREQ  = 3'd2,
        CFG_PWM_FREQ  = 3'd3,
        CFG_INIT_FREQ = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [ACC_W-1:0]  accel;
        logic [IDX_W-1:0]  nom_idx;
        logic [FREQ_W-1:0] nom_freq;
        logic [PWM_W-1:0]  pwm_freq;
        logic [FREQ_W-1:0] init_freq;
    } cfg_t;

    typedef struct packed {
        logic [FREQ_W-1:0]   cur_freq;
        logic [IDX_W-1:0]    mod_index;
        logic [PH_OUT_W-1:0] phase;
        logic                at_target;
    } res_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [DIV_QW-1:0] bits;
        logic [CNT_W-1:0]  steps;
        logic [REM_W-1:0]  divisor;
    } div_req_t;

endpackage

// ----- rtl/vfr_div_unit.sv -----
module vfr_div_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  vfr_pkg::div_req_t          req,
    output logic                       done,
    output logic [vfr_pkg::DIV_QW-1:0] quot
);
    import vfr_pkg::*;

    logic                 busy_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [DIV_QW-1:0]    bits_reg;
    logic [DIV_QW-1:0]    q_reg;
    logic [REM_W-1:0]     div_reg;

    logic [REM_W:0]       rem_sh;
    logic [REM_W:0]       diff;
    logic                 ge;
    logic [REM_W-1:0]     rem_next;
    logic                 stepping;

    // one restoring step per cycle, dividend bits enter msb first
    assign rem_sh   = {rem_reg, bits_reg[DIV_QW-1]};
    assign diff     = rem_sh - {1'b0, div_reg};
    assign ge       = (rem_sh >= {1'b0, div_reg});
    assign rem_next = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
    assign stepping = busy_reg && (cnt_reg != '0);

    assign done = busy_reg && (cnt_reg == '0);
    assign quot = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= req.steps;
        end else if (done) begin
            busy_reg <= 1'b0;
        end else if (stepping) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= req.rem;
            bits_reg <= req.bits;
            div_reg  <= req.divisor;
            q_reg    <= '0;
        end else if (stepping) begin
            rem_reg  <= rem_next;
            bits_reg <= bits_reg << 1;
            q_reg    <= {q_reg[DIV_QW-2:0], ge};
        end
    end

endmodule

// ----- rtl/vfr_core.sv -----
module vfr_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  vfr_pkg::cfg_t              cfg,
    input  logic                       start,
    input  logic [vfr_pkg::FREQ_W-1:0] req_freq,
    input  logic                       restart,
    output logic                       idle,
    output logic                       done,
    input  logic                       res_ready,
    output vfr_pkg::res_t              res
);
    import vfr_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_RAMP = 9'b000000010,
        ST_UP   = 9'b000000100,
        ST_DN   = 9'b000001000,
        ST_IMUL = 9'b000010000,
        ST_ICHK = 9'b000100000,
        ST_IDIV = 9'b001000000,
        ST_PDIV = 9'b010000000,
        ST_DONE = 9'b100000000
    } state_t;

    state_t                state_reg, state_next;
    logic [FREQ_W-1:0]     f_reg, f_next;
    logic [FREQ_W-1:0]     tgt_reg;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [PROD_W-1:0]     prod_reg;
    logic [IDX_W-1:0]      idx_reg, idx_next;

    logic [ACC_W-1:0]      a_eff;
    logic [FREQ_W-1:0]     nf_eff;
    logic [PWM_W-1:0]      pf_eff;
    logic [ACC_W-1:0]      mul_b;

    logic [FREQ_W:0]       up_raw;
    logic [FREQ_W:0]       up_bump;
    logic [FREQ_W-1:0]     f_up;
    logic [FREQ_W-1:0]     dn_q;
    logic [FREQ_W-1:0]     f_dn;

    logic [IDX_PROD_W-1:0] idx_prod;
    logic [FREQ_W-1:0]     idx_hi;
    logic                  idx_ovf;

    logic                  div_start;
    div_req_t              div_req;
    logic                  div_done;
    logic [DIV_QW-1:0]     div_q;

    vfr_div_unit u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .req     (div_req),
        .done    (div_done),
        .quot    (div_q)
    );

    assign a_eff  = (cfg.accel < ONE_Q30) ? ONE_Q30 : cfg.accel;
    assign nf_eff = (cfg.nom_freq == '0) ? FREQ_W'(1) : cfg.nom_freq;
    assign pf_eff = (cfg.pwm_freq == '0) ? PWM_W'(1) : cfg.pwm_freq;
    assign mul_b  = (state_reg == ST_IMUL) ? ACC_W'(cfg.nom_idx) : a_eff;

    // geometric step up, forced to progress by one lsb when rounding stalls it
    assign up_raw  = prod_reg[PROD_W-1:Q30_SH];
    assign up_bump = ((up_raw == {1'b0, f_reg}) && (a_eff > ONE_Q30) && (f_reg != '0))
                     ? ({1'b0, f_reg} + (FREQ_W+1)'(1)) : up_raw;
    assign f_up    = (up_bump > {1'b0, tgt_reg}) ? tgt_reg : up_bump[FREQ_W-1:0];

    assign dn_q = div_q[FREQ_W-1:0];
    assign f_dn = (dn_q < tgt_reg) ? tgt_reg : dn_q;

    // quotient reaches 2^17 exactly when the upper product bits reach the divisor
    assign idx_prod = prod_reg[IDX_PROD_W-1:0];
    assign idx_hi   = idx_prod[IDX_PROD_W-1:IDX_W];
    assign idx_ovf  = (idx_hi >= nf_eff);

    always_comb begin
        div_start       = 1'b0;
        div_req.rem     = '0;
        div_req.bits    = '0;
        div_req.steps   = CNT_W'(DIV_QW);
        div_req.divisor = REM_W'(pf_eff);
        unique case (state_reg)
            ST_RAMP: begin
                div_start       = (f_reg > tgt_reg);
                div_req.rem     = REM_W'(f_reg) << RAMP_SH;
                div_req.steps   = CNT_W'(FREQ_W);
                div_req.divisor = a_eff;
            end
            ST_ICHK: begin
                div_start = 1'b1;
                if (!idx_ovf) begin
                    div_req.rem     = REM_W'(idx_hi);
                    div_req.bits    = DIV_QW'(idx_prod[IDX_W-1:0]) << (DIV_QW - IDX_W);
                    div_req.steps   = CNT_W'(IDX_W);
                    div_req.divisor = REM_W'(nf_eff);
                end else begin
                    div_req.bits = DIV_QW'(f_reg) << (PHASE_BITS - 16);
                end
            end
            ST_IDIV: begin
                div_start    = div_done;
                div_req.bits = DIV_QW'(f_reg) << (PHASE_BITS - 16);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        f_next     = f_reg;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_RAMP;
                    if (restart) begin
                        f_next     = cfg.init_freq;
                        phase_next = '0;
                    end
                end
            end
            ST_RAMP: begin
                if (f_reg < tgt_reg) begin
                    state_next = ST_UP;
                end else if (f_reg > tgt_reg) begin
                    state_next = ST_DN;
                end else begin
                    state_next = ST_IMUL;
                end
            end
            ST_UP: begin
                f_next     = f_up;
                state_next = ST_IMUL;
            end
            ST_DN: begin
                if (div_done) begin
                    f_next     = f_dn;
                    state_next = ST_IMUL;
                end
            end
            ST_IMUL: begin
                state_next = ST_ICHK;
            end
            ST_ICHK: begin
                if (idx_ovf) begin
                    idx_next   = IDX_MAX;
                    state_next = ST_PDIV;
                end else begin
                    state_next = ST_IDIV;
                end
            end
            ST_IDIV: begin
                if (div_done) begin
                    idx_next   = div_q[IDX_W-1:0];
                    state_next = ST_PDIV;
                end
            end
            ST_PDIV: begin
                if (div_done) begin
                    phase_next = phase_reg + div_q[PHASE_BITS-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            f_reg     <= INIT_FREQ_RST;
            phase_reg <= '0;
        end else begin
            state_reg <= state_next;
            f_reg     <= f_next;
            phase_reg <= phase_next;
        end
    end

    // one shared multiplier: ramp product first, then index product
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_RAMP) || (state_reg == ST_IMUL)) begin
            prod_reg <= PROD_W'(f_reg) * PROD_W'(mul_b);
        end
        if (state_reg == ST_IDLE && start) begin
            tgt_reg <= req_freq;
        end
        idx_reg <= idx_next;
    end

    assign idle = (state_reg == ST_IDLE);
    assign done = (state_reg == ST_DONE);

    assign res.cur_freq  = f_reg;
    assign res.mod_index = idx_reg;
    assign res.phase     = PH_OUT_W'({phase_reg, PH_OUT_W'(0)} >> PHASE_BITS);
    assign res.at_target = (f_reg == tgt_reg);

endmodule

// ----- rtl/vf_ramp_phase_generator.sv -----
// open-loop v/f ramp and phase generator, one item per pwm period
//
// s_ channel: s_tdata carries the requested frequency (q10.16), s_tuser the
// restart flag. m_ channel: a result item with the ramped frequency, the
// modulation index (q1.16, saturated), the phase word and the at-target flag.
// cfg_we/cfg_idx/cfg_wdata write the five ramp registers; write only while idle.
//
// each item runs through one shared multiplier and one bit-serial restoring
// divider under a small sequencer: up to three divisions one quotient bit a
// cycle, the phase-step division being 42 bits long. s_tready rises again in
// the cycle the result is loaded, so a new item is taken only after the last
// one's result is loaded.
//
// reset loads the frequency with the initial-frequency reset value, clears the
// phase and restores all register defaults. a stalled receiver holds the
// result in the output register; one more item is worked on meanwhile and
// waits at its end until the output register frees up.
module vf_ramp_phase_generator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [vfr_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [vfr_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [vfr_pkg::IN_DATA_W-1:0]  s_tdata,  // req_freq[25:0]
    input  logic [0:0]                     s_tuser,  // restart[0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [vfr_pkg::OUT_DATA_W-1:0] m_tdata,  // cur_freq[25:0], mod_index[42:26], phase[74:43]
    output logic [0:0]                     m_tuser   // at_target[0]
);
    import vfr_pkg::*;

    cfg_t                   cfg_reg;
    logic                   m_tvalid_reg;
    logic [OUT_DATA_W-1:0]  m_tdata_reg;
    logic [0:0]             m_tuser_reg;

    logic                   core_idle;
    logic                   core_done;
    logic                   res_ready;
    logic                   start;
    res_t                   res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.accel     <= ACCEL_RST;
            cfg_reg.nom_idx   <= NOM_IDX_RST;
            cfg_reg.nom_freq  <= NOM_FREQ_RST;
            cfg_reg.pwm_freq  <= PWM_RST;
            cfg_reg.init_freq <= INIT_FREQ_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                CFG_ACCEL:     cfg_reg.accel     <= cfg_wdata[ACC_W-1:0];
                CFG_NOM_IDX:   cfg_reg.nom_idx   <= cfg_wdata[IDX_W-1:0];
                CFG_NOM_FREQ:  cfg_reg.nom_freq  <= cfg_wdata[FREQ_W-1:0];
                CFG_PWM_FREQ:  cfg_reg.pwm_freq  <= cfg_wdata[PWM_W-1:0];
                CFG_INIT_FREQ: cfg_reg.init_freq <= cfg_wdata[FREQ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_tready  = core_idle;
    assign start     = s_tvalid && core_idle;
    assign res_ready = !m_tvalid_reg || m_tready;

    vfr_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .start     (start),
        .req_freq  (s_tdata[FREQ_W-1:0]),
        .restart   (s_tuser[0]),
        .idle      (core_idle),
        .done      (core_done),
        .res_ready (res_ready),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (core_done && res_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_done && res_ready) begin
            m_tdata_reg <= OUT_DATA_W'({res.phase, res.mod_index, res.cur_freq});
            m_tuser_reg <= res.at_target;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- rtl/vfr_checker.sv -----
module vfr_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [vfr_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [0:0]                     m_tuser
);
    import vfr_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

    // an accepted item keeps the block busy, with s_tready low, after the accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (!s_tready ##1 !s_tready))
        else $error("input taken again while an item is at work");

    // a new result only comes out of a busy block
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without an item at work");

    // fill bits of the result stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_DATA_W-1:OUT_USED_W] == '0))
        else $error("nonzero fill bits in result");

endmodule

bind vf_ramp_phase_generator vfr_checker u_vfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/sv/tb_vf_ramp_phase_generator.sv -----
`timescale 1ns / 100ps

module tb_vf_ramp_phase_generator;
    import vfr_pkg::*;

    localparam int RANDOM_ITEMS = 1950;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 100;
    localparam logic [FREQ_W-1:0] FREQ_TOP = '1;
    localparam logic [PWM_W-1:0]  PWM_MIN  = 20'd1000;
    localparam logic [PWM_W-1:0]  PWM_MAX  = 20'd1000000;
    localparam logic [FREQ_W-1:0] NOM_FREQ_MIN = 26'd65536;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;  // req_freq[25:0]
    logic [0:0]            s_tuser   = '0;  // restart[0]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // cur_freq[25:0], mod_index[42:26], phase[74:43]
    logic [0:0]            m_tuser;         // at_target[0]

    // local copy of the ramp registers and state
    logic [ACC_W-1:0]      accel_q30;
    logic [IDX_W-1:0]      nom_index;
    logic [FREQ_W-1:0]     nom_freq;
    logic [PWM_W-1:0]      pwm_rate;
    logic [FREQ_W-1:0]     start_freq;
    logic [FREQ_W-1:0]     model_freq;
    logic [PHASE_BITS-1:0] model_phase;

    res_t pending_steps[$];
    int   mismatch_count = 0;
    int   random_items   = 0;
    int   burst_left     = 0;
    bit   pace_on        = 1'b1;

    vf_ramp_phase_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic res_t ramp_and_advance(logic [FREQ_W-1:0] req, logic restart);
        logic [63:0] a, f, tgt, n, nf, pf, idx, step, acc;
        int up, dn;
        res_t r;
        a   = (accel_q30 < ONE_Q30) ? 64'(ONE_Q30) : 64'(accel_q30);
        tgt = 64'(req);
        if (restart) begin
            model_freq  = start_freq;
            model_phase = '0;
        end
        f = 64'(model_freq);
        if (f < tgt) begin
            n = (f * a) >> Q30_SH;
            // a factor just above one must still move the frequency
            if (n == f && a > 64'(ONE_Q30) && f != 0) n = f + 1;
            if (n > tgt) n = tgt;
            f = n;
        end
        if (f > tgt) begin
            n = (f << Q30_SH) / a;
            if (n < tgt) n = tgt;
            f = n;
        end
        model_freq = f[FREQ_W-1:0];
        nf  = (nom_freq == 0) ? 64'd1 : 64'(nom_freq);
        idx = (64'(nom_index) * 64'(model_freq)) / nf;
        if (idx > 64'(IDX_MAX)) idx = 64'(IDX_MAX);
        pf   = (pwm_rate == 0) ? 64'd1 : 64'(pwm_rate);
        step = (64'(model_freq) << (PHASE_BITS - 16)) / pf;
        model_phase = model_phase + step[PHASE_BITS-1:0];
        up  = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
        dn  = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
        acc = 64'(model_phase);
        r.cur_freq  = model_freq;
        r.mod_index = idx[IDX_W-1:0];
        r.phase     = PH_OUT_W'((acc >> up) << dn);
        r.at_target = (model_freq == req);
        return r;
    endfunction

    task automatic send_item(logic [FREQ_W-1:0] req, logic restart);
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'(req);
        s_tuser  <= restart;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_steps.push_back(ramp_and_advance(req, restart));
        @(negedge aclk);
    endtask

    task automatic paced_send(logic [FREQ_W-1:0] req, logic restart);
        int gap;
        if (pace_on) begin
            if (burst_left == 0) begin
                case ($urandom_range(0, 7))
                    0:       gap = $urandom_range(20, 150);
                    1, 2:    gap = 0;
                    default: gap = $urandom_range(1, 6);
                endcase
                burst_left = $urandom_range(1, 12);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            burst_left--;
        end
        send_item(req, restart);
    endtask

    // lowers the input valid and waits until every result is back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_steps.size() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // caller lowers cfg_we after the last write of a group
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_ACCEL:     accel_q30  = value[ACC_W-1:0];
            CFG_NOM_IDX:   nom_index  = value[IDX_W-1:0];
            CFG_NOM_FREQ:  nom_freq   = value[FREQ_W-1:0];
            CFG_PWM_FREQ:  pwm_rate   = value[PWM_W-1:0];
            CFG_INIT_FREQ: start_freq = value[FREQ_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    function automatic logic [FREQ_W-1:0] pick_target();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return FREQ_TOP;
            2:       return start_freq;
            3:       return model_freq;
            4, 5:    return FREQ_W'($urandom_range(1 << 22, 1 << 16));
            default: return FREQ_W'($urandom);
        endcase
    endfunction

    task automatic program_random_settings();
        case ($urandom_range(0, 7))
            0:       write_reg(CFG_ACCEL, ONE_Q30);
            1:       write_reg(CFG_ACCEL, '1);
            2:       write_reg(CFG_ACCEL, CFG_W'($urandom_range(ONE_Q30 - 1, 0)));
            3, 4:    write_reg(CFG_ACCEL, CFG_W'(ONE_Q30 + $urandom_range(1 << 22, 0)));
            default: write_reg(CFG_ACCEL, CFG_W'($urandom_range(32'h7FFF_FFFF, ONE_Q30)));
        endcase
        case ($urandom_range(0, 5))
            0:       write_reg(CFG_NOM_IDX, '0);
            1:       write_reg(CFG_NOM_IDX, CFG_W'(IDX_MAX));
            2:       write_reg(CFG_NOM_IDX, CFG_W'($urandom));
            default: write_reg(CFG_NOM_IDX, CFG_W'($urandom_range(IDX_MAX, 0)));
        endcase
        case ($urandom_range(0, 7))
            0:       write_reg(CFG_NOM_FREQ, CFG_W'(NOM_FREQ_MIN));
            1:       write_reg(CFG_NOM_FREQ, CFG_W'(FREQ_TOP));
            2:       write_reg(CFG_NOM_FREQ, '0);
            3:       write_reg(CFG_NOM_FREQ, CFG_W'($urandom));
            default: write_reg(CFG_NOM_FREQ, CFG_W'($urandom_range(FREQ_TOP, NOM_FREQ_MIN)));
        endcase
        case ($urandom_range(0, 7))
            0:       write_reg(CFG_PWM_FREQ, CFG_W'(PWM_MIN));
            1:       write_reg(CFG_PWM_FREQ, CFG_W'(PWM_MAX));
            2:       write_reg(CFG_PWM_FREQ, '0);
            3:       write_reg(CFG_PWM_FREQ, CFG_W'($urandom));
            default: write_reg(CFG_PWM_FREQ, CFG_W'($urandom_range(PWM_MAX, PWM_MIN)));
        endcase
        case ($urandom_range(0, 5))
            0:       write_reg(CFG_INIT_FREQ, '0);
            1:       write_reg(CFG_INIT_FREQ, CFG_W'(FREQ_TOP));
            2, 3:    write_reg(CFG_INIT_FREQ, CFG_W'($urandom_range(1 << 22, 1)));
            default: write_reg(CFG_INIT_FREQ, CFG_W'($urandom));
        endcase
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_state();
        paced_send(26'd3276800, 1'b0);
        paced_send(26'd3276800, 1'b0);
        paced_send(26'd65536, 1'b1);
    endtask

    task automatic test_zero_frequency();
        wait_idle();
        write_reg(CFG_INIT_FREQ, '0);
        cfg_we <= 1'b0;
        paced_send(FREQ_TOP, 1'b1);
        paced_send(FREQ_TOP, 1'b0);
        paced_send('0, 1'b0);
    endtask

    task automatic test_unit_factor();
        wait_idle();
        write_reg(CFG_ACCEL, CFG_W'(ONE_Q30 - 1));
        write_reg(CFG_INIT_FREQ, CFG_W'(INIT_FREQ_RST));
        cfg_we <= 1'b0;
        paced_send(26'd1000000, 1'b1);
        paced_send(26'd1000000, 1'b0);
        wait_idle();
        write_reg(CFG_ACCEL, ONE_Q30);
        cfg_we <= 1'b0;
        paced_send(26'd1000000, 1'b0);
        wait_idle();
        write_reg(CFG_ACCEL, '0);
        cfg_we <= 1'b0;
        paced_send('0, 1'b0);
    endtask

    task automatic test_ramp_extremes();
        wait_idle();
        write_reg(CFG_ACCEL, '1);
        write_reg(CFG_INIT_FREQ, CFG_W'(FREQ_TOP));
        cfg_we <= 1'b0;
        // roughly halving toward zero, then doubling toward the top
        paced_send('0, 1'b1);
        paced_send('0, 1'b0);
        paced_send('0, 1'b0);
        paced_send(FREQ_TOP, 1'b0);
        paced_send(FREQ_TOP, 1'b0);
    endtask

    task automatic test_scale_extremes();
        wait_idle();
        write_reg(CFG_NOM_IDX, CFG_W'(IDX_MAX));
        write_reg(CFG_NOM_FREQ, '0);
        write_reg(CFG_PWM_FREQ, '0);
        cfg_we <= 1'b0;
        paced_send(FREQ_TOP, 1'b1);
        wait_idle();
        write_reg(CFG_NOM_FREQ, CFG_W'(FREQ_TOP));
        write_reg(CFG_PWM_FREQ, CFG_W'(PWM_MAX));
        cfg_we <= 1'b0;
        paced_send(FREQ_TOP, 1'b0);
        wait_idle();
        write_reg(CFG_NOM_IDX, '0);
        write_reg(CFG_NOM_FREQ, CFG_W'(NOM_FREQ_MIN));
        write_reg(CFG_PWM_FREQ, CFG_W'(PWM_MIN));
        cfg_we <= 1'b0;
        paced_send(26'd1, 1'b0);
        wait_idle();
        // upper write-data bits past the register width are dropped
        write_reg(CFG_NOM_IDX, '1);
        cfg_we <= 1'b0;
        paced_send(FREQ_TOP, 1'b0);
    endtask

    task automatic test_unused_index();
        wait_idle();
        for (int k = 1; k <= 3; k++)
            write_reg(CFG_IDX_W'(CFG_INIT_FREQ) + CFG_IDX_W'(k), '1);
        cfg_we <= 1'b0;
        paced_send(26'd3276800, 1'b1);
        paced_send(26'd3276800, 1'b0);
    endtask

    task automatic test_random_settings();
        int phase_items, n, seq_len;
        bit restart_seq, first;
        logic [FREQ_W-1:0] target;
        while (random_items < RANDOM_ITEMS) begin
            wait_idle();
            program_random_settings();
            pace_on     = ($urandom_range(0, 3) != 0);
            burst_left  = 0;
            phase_items = $urandom_range(60, 200);
            n = 0;
            while (n < phase_items) begin
                seq_len     = $urandom_range(4, 40);
                target      = pick_target();
                restart_seq = ($urandom_range(0, 2) == 0);
                first       = 1'b1;
                repeat (seq_len) begin
                    if ($urandom_range(0, 7) == 0)
                        paced_send(FREQ_W'($urandom), 1'($urandom));
                    else
                        paced_send(target, first && restart_seq);
                    first = 1'b0;
                    n++;
                    random_items++;
                end
            end
        end
    endtask

    // receiver ready pattern: always ready, light random stalls, long stalls
    initial begin : sink_pattern
        int mode, left, hold;
        bit level;
        mode  = 0;
        left  = 0;
        hold  = 0;
        level = 1'b1;
        forever begin
            @(negedge aclk);
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(64, 512);
            end
            left--;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: begin
                    if (hold == 0) begin
                        level = !level;
                        hold  = level ? $urandom_range(1, 20) : $urandom_range(1, 200);
                    end
                    hold--;
                    m_tready <= level;
                end
            endcase
        end
    end

    always @(posedge aclk) begin : result_check
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_steps.size() == 0) begin
                $error("result item with no expectation: m_tdata=%h m_tuser=%b",
                       m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                want = pending_steps.pop_front();
                if (m_tdata[0 +: FREQ_W] !== want.cur_freq) begin
                    $error("cur_freq expected %0d actual %0d",
                           want.cur_freq, m_tdata[0 +: FREQ_W]);
                    mismatch_count++;
                end
                if (m_tdata[FREQ_W +: IDX_W] !== want.mod_index) begin
                    $error("mod_index expected %0d actual %0d",
                           want.mod_index, m_tdata[FREQ_W +: IDX_W]);
                    mismatch_count++;
                end
                if (m_tdata[FREQ_W + IDX_W +: PH_OUT_W] !== want.phase) begin
                    $error("phase expected %h actual %h",
                           want.phase, m_tdata[FREQ_W + IDX_W +: PH_OUT_W]);
                    mismatch_count++;
                end
                if (m_tuser[0] !== want.at_target) begin
                    $error("at_target expected %b actual %b", want.at_target, m_tuser[0]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL vf_ramp_phase_generator");
        $finish;
    end

    initial begin
        accel_q30   = ACCEL_RST;
        nom_index   = NOM_IDX_RST;
        nom_freq    = NOM_FREQ_RST;
        pwm_rate    = PWM_RST;
        start_freq  = INIT_FREQ_RST;
        model_freq  = INIT_FREQ_RST;
        model_phase = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_state();
        test_zero_frequency();
        test_unit_factor();
        test_ramp_extremes();
        test_scale_extremes();
        test_unused_index();
        test_random_settings();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_steps.size() == 0)
            $display("PASS vf_ramp_phase_generator");
        else
            $display("FAIL vf_ramp_phase_generator");
        $finish;
    end

endmodule
